// ===== hw/rtl/slab_object_allocator_defines.svh =====
// Assertion macros shared by the slab object allocator checkers.
`ifndef SLAB_OBJECT_ALLOCATOR_DEFINES_SVH
`define SLAB_OBJECT_ALLOCATOR_DEFINES_SVH

// A payload that is offered and stalled holds its value in the next cycle.
`define SOA_ASSERT_HOLD(label, clk, rst, vld, stl, sig) \
   label: assert property (@(posedge clk) disable iff (rst) \
      (vld && stl) |=> $stable(sig)) else $error("stalled payload changed");

// A condition that must hold in the same cycle.
`define SOA_ASSERT_IMPLY(label, clk, rst, cond, prop) \
   label: assert property (@(posedge clk) disable iff (rst) \
      (cond) |-> (prop)) else $error("same-cycle implication failed");

// A condition that must hold in the following cycle.
`define SOA_ASSERT_NEXT(label, clk, rst, cond, prop) \
   label: assert property (@(posedge clk) disable iff (rst) \
      (cond) |=> (prop)) else $error("next-cycle implication failed");

`endif

// ===== hw/rtl/soa_pkg.sv =====
// Shared constants, payload types and control types of the slab object allocator.
`timescale 1ns / 1ps
package soa_pkg;

   // Pool geometry.
   localparam int POOL_SLABS   = 16;
   localparam int MAX_OBJECTS  = 512;
   localparam int HEADER_BYTES = 32;
   localparam int PAGE_SHIFT   = 12;

   // Fixed field widths.
   localparam int ADDR_W     = 26;
   localparam int BYTES_W    = 19;
   localparam int ORDER_W    = 4;
   localparam int OPS_W      = 10;
   localparam int RELEASED_W = 5;
   localparam int FUNC_W     = 2;
   localparam int CSR_IDX_W  = 2;
   localparam int CSR_W      = 19;
   localparam int SHIFT_W    = 5;
   localparam int MIN_BYTES  = 8;

   // Derived widths.
   localparam int SLAB_IW    = (POOL_SLABS > 1) ? $clog2(POOL_SLABS) : 1;
   localparam int LINK_W     = $clog2(POOL_SLABS + 1);
   localparam int OBJ_IW     = (MAX_OBJECTS > 1) ? $clog2(MAX_OBJECTS) : 1;
   localparam int CNT_W      = $clog2(MAX_OBJECTS + 1);
   localparam int MEM_AW     = SLAB_IW + OBJ_IW;
   localparam int MEM_DEPTH  = POOL_SLABS * MAX_OBJECTS;
   localparam int PROD_W     = CNT_W + BYTES_W;
   localparam int DIV_CNT_W  = $clog2(ADDR_W + 1);

   localparam logic [LINK_W-1:0] NIL_SLAB = LINK_W'(POOL_SLABS);

   // Request function codes.
   localparam logic [FUNC_W-1:0] FUNC_ALLOC   = 2'd0;
   localparam logic [FUNC_W-1:0] FUNC_FREE    = 2'd1;
   localparam logic [FUNC_W-1:0] FUNC_SHRINK  = 2'd2;
   localparam logic [FUNC_W-1:0] FUNC_RELEASE = 2'd3;

   // Slab list kinds.
   localparam logic [1:0] KIND_EMPTY   = 2'd0;
   localparam logic [1:0] KIND_PARTIAL = 2'd1;
   localparam logic [1:0] KIND_FULL    = 2'd2;

   // Register indexes.
   localparam logic [CSR_IDX_W-1:0] CSR_OBJECT_BYTES     = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_SLAB_ORDER       = 2'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_OBJECTS_PER_SLAB = 2'd2;

   typedef struct packed {
      logic [FUNC_W-1:0] func;
      logic [ADDR_W-1:0] free_address;
   } req_type;

   typedef struct packed {
      logic [ADDR_W-1:0]     object_address;
      logic                  status;
      logic [RELEASED_W-1:0] slabs_released;
   } rsp_type;

   // Datapath commands issued by the controller.
   typedef enum logic [3:0] {
      CMD_IDLE,
      CMD_LOAD,
      CMD_SELECT,
      CMD_PUSH,
      CMD_INIT,
      CMD_READ,
      CMD_ALLOC,
      CMD_FCHECK,
      CMD_DIVIDE,
      CMD_FREE,
      CMD_MOVE,
      CMD_UNLINK,
      CMD_SHRINK,
      CMD_RELEASE,
      CMD_RESP
   } cmd_type;

   // Datapath status seen by the controller.
   typedef struct packed {
      logic [FUNC_W-1:0] func;
      logic              list_hit;
      logic              free_found;
      logic              init_last;
      logic              free_ok;
      logic              div_done;
      logic              move_needed;
      logic              shrink_done;
      logic              rsp_busy;
   } status_type;

endpackage

// ===== hw/rtl/soa_datapath.sv =====
// Slab tables, object link memory, divider, address arithmetic and result register.
`timescale 1ns / 1ps
module soa_datapath (
   input  logic                               clock,
   input  logic                               reset,
   input  soa_pkg::cmd_type                   cmd,
   output soa_pkg::status_type                status,
   input  soa_pkg::req_type                   req_data,
   input  logic                               csr_write,
   input  logic [soa_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [soa_pkg::CSR_W-1:0]          csr_wdata,
   output logic                               rsp_valid,
   input  logic                               rsp_stall,
   output soa_pkg::rsp_type                   rsp_data
);

   localparam int P = soa_pkg::POOL_SLABS;

   // Configuration registers.
   logic [soa_pkg::BYTES_W-1:0] obj_bytes_ff;
   logic [soa_pkg::ORDER_W-1:0] order_ff;
   logic [soa_pkg::OPS_W-1:0]   ops_ff;

   // Slab tables.
   logic                        claimed_ff [P];
   logic [1:0]                  kind_ff    [P];
   logic [soa_pkg::CNT_W-1:0]   count_ff   [P];
   logic [soa_pkg::CNT_W-1:0]   head_ff    [P];
   logic [soa_pkg::LINK_W-1:0]  next_ff    [P];
   logic [soa_pkg::LINK_W-1:0]  prev_ff    [P];
   logic [soa_pkg::LINK_W-1:0]  heads_ff   [3];

   // Transaction registers.
   logic [soa_pkg::FUNC_W-1:0]    func_ff;
   logic [soa_pkg::ADDR_W-1:0]    addr_ff;
   logic [soa_pkg::SLAB_IW-1:0]   s_ff;
   logic [soa_pkg::CNT_W-1:0]     k_ff;
   logic [1:0]                    target_ff;
   logic                          move_en_ff;
   logic [soa_pkg::CNT_W-1:0]     init_ctr_ff;
   logic [soa_pkg::LINK_W-1:0]    walk_ff;
   logic [soa_pkg::LINK_W-1:0]    guard_ff;
   logic [soa_pkg::LINK_W-1:0]    released_ff;
   logic [soa_pkg::PROD_W-1:0]    prod_ff;
   logic [soa_pkg::BYTES_W-1:0]   rem_ff;
   logic [soa_pkg::ADDR_W-1:0]    quo_ff;
   logic [soa_pkg::DIV_CNT_W-1:0] div_ctr_ff;
   logic [soa_pkg::ADDR_W-1:0]    res_addr_ff;
   logic                          res_status_ff;
   logic                          rsp_valid_ff;
   soa_pkg::rsp_type              rsp_data_ff;

   // Object link memory.
   logic [soa_pkg::CNT_W-1:0]  obj_mem [soa_pkg::MEM_DEPTH];
   logic [soa_pkg::CNT_W-1:0]  mem_q_ff;
   logic                       mem_we;
   logic [soa_pkg::MEM_AW-1:0] mem_waddr;
   logic [soa_pkg::CNT_W-1:0]  mem_wdata;
   logic [soa_pkg::MEM_AW-1:0] mem_raddr;

   // Derived configuration.
   logic [soa_pkg::BYTES_W-1:0] size;
   logic [soa_pkg::CNT_W-1:0]   cnt;
   logic [soa_pkg::SHIFT_W-1:0] shift;

   always_comb begin
      size  = (obj_bytes_ff < soa_pkg::BYTES_W'(soa_pkg::MIN_BYTES)) ?
              soa_pkg::BYTES_W'(soa_pkg::MIN_BYTES) : obj_bytes_ff;
      if (ops_ff == '0) begin
         cnt = soa_pkg::CNT_W'(1);
      end else if (int'(ops_ff) > soa_pkg::MAX_OBJECTS) begin
         cnt = soa_pkg::CNT_W'(soa_pkg::MAX_OBJECTS);
      end else begin
         cnt = soa_pkg::CNT_W'(ops_ff);
      end
      shift = soa_pkg::SHIFT_W'(soa_pkg::PAGE_SHIFT) + soa_pkg::SHIFT_W'(order_ff);
   end

   // Slab selection for alloc: list heads first, then the lowest unclaimed slab.
   logic                        part_ok;
   logic                        empty_ok;
   logic                        list_hit;
   logic [soa_pkg::SLAB_IW-1:0] list_slab;
   logic                        free_found;
   logic [soa_pkg::SLAB_IW-1:0] free_idx;

   always_comb begin
      part_ok    = heads_ff[soa_pkg::KIND_PARTIAL] < soa_pkg::NIL_SLAB;
      empty_ok   = heads_ff[soa_pkg::KIND_EMPTY] < soa_pkg::NIL_SLAB;
      list_hit   = part_ok || empty_ok;
      list_slab  = part_ok ? heads_ff[soa_pkg::KIND_PARTIAL][soa_pkg::SLAB_IW-1:0] :
                             heads_ff[soa_pkg::KIND_EMPTY][soa_pkg::SLAB_IW-1:0];
      free_found = 1'b0;
      free_idx   = '0;
      for (int i = P - 1; i >= 0; i--) begin
         if (!claimed_ff[i]) begin
            free_found = 1'b1;
            free_idx   = soa_pkg::SLAB_IW'(i);
         end
      end
   end

   // Current slab views.
   logic [soa_pkg::CNT_W-1:0] head_clamped;
   logic [soa_pkg::CNT_W-1:0] cnt_dec;
   logic [soa_pkg::CNT_W-1:0] cnt_inc;

   always_comb begin
      head_clamped = (int'(head_ff[s_ff]) >= soa_pkg::MAX_OBJECTS) ? '0 : head_ff[s_ff];
      cnt_dec      = (count_ff[s_ff] != '0) ? count_ff[s_ff] - 1'b1 : count_ff[s_ff];
      cnt_inc      = count_ff[s_ff] + 1'b1;
   end

   // Free address decode.
   logic [soa_pkg::ADDR_W-1:0]  si_wide;
   logic [soa_pkg::SLAB_IW-1:0] fs;
   logic [soa_pkg::ADDR_W-1:0]  off;
   logic                        free_ok;

   always_comb begin
      si_wide = addr_ff >> shift;
      fs      = si_wide[soa_pkg::SLAB_IW-1:0];
      off     = addr_ff & ~({soa_pkg::ADDR_W{1'b1}} << shift);
      free_ok = (si_wide < soa_pkg::ADDR_W'(P)) && claimed_ff[fs] &&
                (off >= soa_pkg::ADDR_W'(soa_pkg::HEADER_BYTES));
   end

   // Restoring divider step: one quotient bit per cycle.
   logic [soa_pkg::BYTES_W:0]   trial;
   logic                        q_bit;
   logic [soa_pkg::BYTES_W-1:0] rem_next;
   logic                        div_done;
   logic                        free_take;

   always_comb begin
      trial    = {rem_ff, quo_ff[soa_pkg::ADDR_W-1]};
      q_bit    = trial >= {1'b0, size};
      rem_next = q_bit ? soa_pkg::BYTES_W'(trial - {1'b0, size}) :
                         trial[soa_pkg::BYTES_W-1:0];
      div_done = div_ctr_ff == soa_pkg::DIV_CNT_W'(soa_pkg::ADDR_W);
      free_take = (quo_ff < soa_pkg::ADDR_W'(cnt)) && (count_ff[s_ff] < cnt);
   end

   // Shrink walker and release count.
   logic                        walk_ok;
   logic [soa_pkg::SLAB_IW-1:0] ws;
   logic [soa_pkg::LINK_W-1:0]  claimed_total;

   always_comb begin
      walk_ok = (walk_ff < soa_pkg::NIL_SLAB) && (guard_ff < soa_pkg::NIL_SLAB);
      ws      = walk_ff[soa_pkg::SLAB_IW-1:0];
      claimed_total = '0;
      for (int i = 0; i < P; i++) begin
         claimed_total = claimed_total + soa_pkg::LINK_W'(claimed_ff[i]);
      end
   end

   // List unlink and push operands.
   logic [soa_pkg::LINK_W-1:0] un_p;
   logic [soa_pkg::LINK_W-1:0] un_n;
   logic [1:0]                 un_k;
   logic [soa_pkg::LINK_W-1:0] push_h;
   logic [soa_pkg::ADDR_W-1:0] alloc_addr;

   always_comb begin
      un_p   = prev_ff[s_ff];
      un_n   = next_ff[s_ff];
      un_k   = kind_ff[s_ff];
      push_h = heads_ff[target_ff];
      alloc_addr = (soa_pkg::ADDR_W'(s_ff) << shift) +
                   soa_pkg::ADDR_W'(soa_pkg::HEADER_BYTES) +
                   prod_ff[soa_pkg::ADDR_W-1:0];
   end

   // Memory port selection.
   always_comb begin
      mem_we    = 1'b0;
      mem_waddr = {s_ff, init_ctr_ff[soa_pkg::OBJ_IW-1:0]};
      mem_wdata = ((init_ctr_ff + 1'b1) < cnt) ? init_ctr_ff + 1'b1 : '0;
      mem_raddr = {s_ff, head_clamped[soa_pkg::OBJ_IW-1:0]};
      case (cmd)
         soa_pkg::CMD_INIT: begin
            mem_we = 1'b1;
         end
         soa_pkg::CMD_FREE: begin
            mem_we    = free_take;
            mem_waddr = {s_ff, quo_ff[soa_pkg::OBJ_IW-1:0]};
            mem_wdata = head_ff[s_ff];
         end
         default: begin
            mem_we = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (mem_we) begin
         obj_mem[mem_waddr] <= mem_wdata;
      end
      if (cmd == soa_pkg::CMD_READ) begin
         mem_q_ff <= obj_mem[mem_raddr];
      end
   end

   // Configuration writes.
   always_ff @(posedge clock) begin
      if (reset) begin
         obj_bytes_ff <= soa_pkg::BYTES_W'(8);
         order_ff     <= '0;
         ops_ff       <= soa_pkg::OPS_W'(508);
      end else if (csr_write) begin
         case (csr_index)
            soa_pkg::CSR_OBJECT_BYTES:     obj_bytes_ff <= csr_wdata;
            soa_pkg::CSR_SLAB_ORDER:       order_ff <= csr_wdata[soa_pkg::ORDER_W-1:0];
            soa_pkg::CSR_OBJECTS_PER_SLAB: ops_ff <= csr_wdata[soa_pkg::OPS_W-1:0];
            default: begin
            end
         endcase
      end
   end

   // Claimed flags, list kinds and list heads, cleared by reset.
   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < P; i++) begin
            claimed_ff[i] <= 1'b0;
            kind_ff[i]    <= soa_pkg::KIND_EMPTY;
         end
         for (int j = 0; j < 3; j++) begin
            heads_ff[j] <= soa_pkg::NIL_SLAB;
         end
      end else begin
         case (cmd)
            soa_pkg::CMD_SELECT: begin
               if (!list_hit && free_found) begin
                  claimed_ff[free_idx] <= 1'b1;
               end
            end
            soa_pkg::CMD_UNLINK: begin
               if (un_p >= soa_pkg::NIL_SLAB) begin
                  heads_ff[un_k] <= (un_n < soa_pkg::NIL_SLAB) ? un_n : soa_pkg::NIL_SLAB;
               end
            end
            soa_pkg::CMD_PUSH: begin
               kind_ff[s_ff]       <= target_ff;
               heads_ff[target_ff] <= soa_pkg::LINK_W'(s_ff);
            end
            soa_pkg::CMD_SHRINK: begin
               if (walk_ok) begin
                  claimed_ff[ws] <= 1'b0;
                  kind_ff[ws]    <= soa_pkg::KIND_EMPTY;
               end else begin
                  heads_ff[soa_pkg::KIND_EMPTY] <= soa_pkg::NIL_SLAB;
               end
            end
            soa_pkg::CMD_RELEASE: begin
               for (int i = 0; i < P; i++) begin
                  claimed_ff[i] <= 1'b0;
                  kind_ff[i]    <= soa_pkg::KIND_EMPTY;
               end
               for (int j = 0; j < 3; j++) begin
                  heads_ff[j] <= soa_pkg::NIL_SLAB;
               end
            end
            default: begin
            end
         endcase
      end
   end

   // Free counts, free heads and slab links, valid once written.
   always_ff @(posedge clock) begin
      case (cmd)
         soa_pkg::CMD_SELECT: begin
            if (!list_hit && free_found) begin
               count_ff[free_idx] <= cnt;
               head_ff[free_idx]  <= '0;
            end
         end
         soa_pkg::CMD_ALLOC: begin
            head_ff[s_ff]  <= mem_q_ff;
            count_ff[s_ff] <= cnt_dec;
         end
         soa_pkg::CMD_FREE: begin
            if (free_take) begin
               head_ff[s_ff]  <= quo_ff[soa_pkg::CNT_W-1:0];
               count_ff[s_ff] <= cnt_inc;
            end
         end
         soa_pkg::CMD_UNLINK: begin
            if (un_p < soa_pkg::NIL_SLAB) begin
               next_ff[un_p[soa_pkg::SLAB_IW-1:0]] <= un_n;
            end
            if (un_n < soa_pkg::NIL_SLAB) begin
               prev_ff[un_n[soa_pkg::SLAB_IW-1:0]] <=
                  (un_p < soa_pkg::NIL_SLAB) ? un_p : soa_pkg::NIL_SLAB;
            end
         end
         soa_pkg::CMD_PUSH: begin
            prev_ff[s_ff] <= soa_pkg::NIL_SLAB;
            next_ff[s_ff] <= (push_h < soa_pkg::NIL_SLAB) ? push_h : soa_pkg::NIL_SLAB;
            if (push_h < soa_pkg::NIL_SLAB) begin
               prev_ff[push_h[soa_pkg::SLAB_IW-1:0]] <= soa_pkg::LINK_W'(s_ff);
            end
         end
         default: begin
         end
      endcase
   end

   // Per-transaction working registers.
   always_ff @(posedge clock) begin
      case (cmd)
         soa_pkg::CMD_LOAD: begin
            func_ff       <= req_data.func;
            addr_ff       <= req_data.free_address;
            move_en_ff    <= 1'b0;
            res_addr_ff   <= '0;
            res_status_ff <= 1'b0;
            released_ff   <= '0;
            walk_ff       <= heads_ff[soa_pkg::KIND_EMPTY];
            guard_ff      <= '0;
         end
         soa_pkg::CMD_SELECT: begin
            target_ff   <= soa_pkg::KIND_EMPTY;
            init_ctr_ff <= '0;
            if (list_hit) begin
               s_ff <= list_slab;
            end else if (free_found) begin
               s_ff <= free_idx;
            end else begin
               res_status_ff <= 1'b1;
            end
         end
         soa_pkg::CMD_INIT: begin
            init_ctr_ff <= init_ctr_ff + 1'b1;
         end
         soa_pkg::CMD_READ: begin
            k_ff <= head_clamped;
         end
         soa_pkg::CMD_ALLOC: begin
            prod_ff    <= soa_pkg::PROD_W'(k_ff) * soa_pkg::PROD_W'(size);
            target_ff  <= (cnt_dec == '0) ? soa_pkg::KIND_FULL : soa_pkg::KIND_PARTIAL;
            move_en_ff <= 1'b1;
         end
         soa_pkg::CMD_FCHECK: begin
            s_ff       <= fs;
            rem_ff     <= '0;
            quo_ff     <= off - soa_pkg::ADDR_W'(soa_pkg::HEADER_BYTES);
            div_ctr_ff <= '0;
         end
         soa_pkg::CMD_DIVIDE: begin
            if (!div_done) begin
               rem_ff     <= rem_next;
               quo_ff     <= {quo_ff[soa_pkg::ADDR_W-2:0], q_bit};
               div_ctr_ff <= div_ctr_ff + 1'b1;
            end
         end
         soa_pkg::CMD_FREE: begin
            target_ff  <= (cnt_inc >= cnt) ? soa_pkg::KIND_EMPTY : soa_pkg::KIND_PARTIAL;
            move_en_ff <= free_take && ((cnt_inc >= cnt) || (cnt_inc == soa_pkg::CNT_W'(1)));
         end
         soa_pkg::CMD_MOVE: begin
            if (func_ff == soa_pkg::FUNC_ALLOC) begin
               res_addr_ff <= alloc_addr;
            end
         end
         soa_pkg::CMD_SHRINK: begin
            if (walk_ok) begin
               if (claimed_ff[ws]) begin
                  released_ff <= released_ff + 1'b1;
               end
               walk_ff  <= next_ff[ws];
               guard_ff <= guard_ff + 1'b1;
            end
         end
         soa_pkg::CMD_RELEASE: begin
            released_ff <= claimed_total;
         end
         default: begin
         end
      endcase
   end

   // Output register: loaded when the previous result has been taken.
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd == soa_pkg::CMD_RESP && !(rsp_valid_ff && rsp_stall)) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd == soa_pkg::CMD_RESP && !(rsp_valid_ff && rsp_stall)) begin
         rsp_data_ff.object_address <= res_addr_ff;
         rsp_data_ff.status         <= res_status_ff;
         rsp_data_ff.slabs_released <= soa_pkg::RELEASED_W'(released_ff);
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // Status toward the controller.
   always_comb begin
      status.func        = func_ff;
      status.list_hit    = list_hit;
      status.free_found  = free_found;
      status.init_last   = init_ctr_ff == (cnt - 1'b1);
      status.free_ok     = free_ok;
      status.div_done    = div_done;
      status.move_needed = move_en_ff && (kind_ff[s_ff] != target_ff);
      status.shrink_done = !walk_ok;
      status.rsp_busy    = rsp_valid_ff && rsp_stall;
   end

endmodule

// ===== hw/rtl/soa_ctrl.sv =====
// Controller state machine that sequences each allocator transaction.
`timescale 1ns / 1ps
module soa_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   output logic                req_stall,
   input  soa_pkg::status_type status,
   output soa_pkg::cmd_type    cmd
);

   typedef enum logic [15:0] {
      ST_IDLE     = 16'h0001,
      ST_DISPATCH = 16'h0002,
      ST_SELECT   = 16'h0004,
      ST_CLAIM    = 16'h0008,
      ST_INIT     = 16'h0010,
      ST_READ     = 16'h0020,
      ST_ALLOC    = 16'h0040,
      ST_FCHECK   = 16'h0080,
      ST_DIVIDE   = 16'h0100,
      ST_FREE     = 16'h0200,
      ST_MOVE     = 16'h0400,
      ST_UNLINK   = 16'h0800,
      ST_PUSH     = 16'h1000,
      ST_SHRINK   = 16'h2000,
      ST_RELEASE  = 16'h4000,
      ST_RESP     = 16'h8000
   } state_type;

   state_type state_ff;
   state_type state_in;

   // Next state and the command for the datapath.
   always_comb begin
      state_in = state_ff;
      cmd      = soa_pkg::CMD_IDLE;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd      = soa_pkg::CMD_LOAD;
               state_in = ST_DISPATCH;
            end
         end
         ST_DISPATCH: begin
            case (status.func)
               soa_pkg::FUNC_ALLOC:  state_in = ST_SELECT;
               soa_pkg::FUNC_FREE:   state_in = ST_FCHECK;
               soa_pkg::FUNC_SHRINK: state_in = ST_SHRINK;
               default:              state_in = ST_RELEASE;
            endcase
         end
         ST_SELECT: begin
            cmd = soa_pkg::CMD_SELECT;
            if (status.list_hit) begin
               state_in = ST_READ;
            end else if (status.free_found) begin
               state_in = ST_CLAIM;
            end else begin
               state_in = ST_RESP;
            end
         end
         ST_CLAIM: begin
            cmd      = soa_pkg::CMD_PUSH;
            state_in = ST_INIT;
         end
         ST_INIT: begin
            cmd = soa_pkg::CMD_INIT;
            if (status.init_last) begin
               state_in = ST_READ;
            end
         end
         ST_READ: begin
            cmd      = soa_pkg::CMD_READ;
            state_in = ST_ALLOC;
         end
         ST_ALLOC: begin
            cmd      = soa_pkg::CMD_ALLOC;
            state_in = ST_MOVE;
         end
         ST_FCHECK: begin
            cmd      = soa_pkg::CMD_FCHECK;
            state_in = status.free_ok ? ST_DIVIDE : ST_RESP;
         end
         ST_DIVIDE: begin
            cmd = soa_pkg::CMD_DIVIDE;
            if (status.div_done) begin
               state_in = ST_FREE;
            end
         end
         ST_FREE: begin
            cmd      = soa_pkg::CMD_FREE;
            state_in = ST_MOVE;
         end
         ST_MOVE: begin
            cmd      = soa_pkg::CMD_MOVE;
            state_in = status.move_needed ? ST_UNLINK : ST_RESP;
         end
         ST_UNLINK: begin
            cmd      = soa_pkg::CMD_UNLINK;
            state_in = ST_PUSH;
         end
         ST_PUSH: begin
            cmd      = soa_pkg::CMD_PUSH;
            state_in = ST_RESP;
         end
         ST_SHRINK: begin
            cmd = soa_pkg::CMD_SHRINK;
            if (status.shrink_done) begin
               state_in = ST_RESP;
            end
         end
         ST_RELEASE: begin
            cmd      = soa_pkg::CMD_RELEASE;
            state_in = ST_RESP;
         end
         ST_RESP: begin
            cmd = soa_pkg::CMD_RESP;
            if (!status.rsp_busy) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign req_stall = state_ff != ST_IDLE;

endmodule

// ===== hw/rtl/slab_object_allocator.sv =====
// Top level of the slab object allocator.
//
// Requests arrive on req_valid/req_stall with req_data carrying func and
// free_address; each transaction returns exactly one result on
// rsp_valid/rsp_stall. Registers are written through csr_write, csr_index
// and csr_wdata; the user must do so while the block is idle (not enforced).
// One transaction is worked on at a time; req_stall is low only in idle.
// Steps of each transaction, all ending with the response:
//   alloc from a listed slab: select, read, alloc, move, and unlink and
//     push when the slab changes list; alloc that claims a slab also
//     pushes and inits it, the claim writing one object link per cycle
//     into the link memory.  out of slabs: select.  release: release.
//   free: check, the one-bit-per-cycle divider mapping offset to object,
//     free, move, and unlink and push on a list move; a free outside any
//     claimed object area ends at the check.  shrink: walks empty slabs.
// The result register lets the next request be accepted while a result
// waits; a stalled result holds, and the following one waits behind it.
// Synchronous reset empties all lists and unclaims all slabs at once.
`timescale 1ns / 1ps
module slab_object_allocator (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  soa_pkg::req_type              req_data,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output soa_pkg::rsp_type              rsp_data,
   input  logic                          csr_write,
   input  logic [soa_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [soa_pkg::CSR_W-1:0]     csr_wdata
);

   soa_pkg::cmd_type    cmd;
   soa_pkg::status_type status;

   // Sequencer.
   soa_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .status    (status),
      .cmd       (cmd)
   );

   // Tables, memory and arithmetic.
   soa_datapath u_datapath (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .status    (status),
      .req_data  (req_data),
      .csr_write (csr_write),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

endmodule

// ===== hw/rtl/soa_checker.sv =====
// Port-level checks of the slab object allocator and their bind.
`timescale 1ns / 1ps
`include "slab_object_allocator_defines.svh"
module soa_checker (
   input logic                          clock,
   input logic                          reset,
   input logic                          req_valid,
   input logic                          req_stall,
   input soa_pkg::req_type              req_data,
   input logic                          rsp_valid,
   input logic                          rsp_stall,
   input soa_pkg::rsp_type              rsp_data,
   input logic                          csr_write,
   input logic [soa_pkg::CSR_IDX_W-1:0] csr_index,
   input logic [soa_pkg::CSR_W-1:0]     csr_wdata
);

   // A stalled result keeps its value.
   `SOA_ASSERT_HOLD(a_rsp_hold, clock, reset, rsp_valid, rsp_stall, rsp_data)

   // An out-of-slabs result never carries an address or a release count.
   `SOA_ASSERT_IMPLY(a_oos_clean, clock, reset, rsp_valid && rsp_data.status, rsp_data.object_address == '0 && rsp_data.slabs_released == '0)

   // A release count never comes with an address or a failure.
   `SOA_ASSERT_IMPLY(a_rel_clean, clock, reset, rsp_valid && rsp_data.slabs_released != '0, rsp_data.object_address == '0 && !rsp_data.status)

   // After a request is taken the block is busy with it.
   `SOA_ASSERT_NEXT(a_busy_after, clock, reset, req_valid && !req_stall, req_stall)

endmodule

bind slab_object_allocator soa_checker u_soa_checker (.*);
